@@ src/qea_pkg.sv @@
// Shared constants, codes and helpers for the quadrature encoder angle core.
// Used by every module in src; depends on nothing.
package qea_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int LOAD_W = 32;
  localparam int CPR_W = 20;
  localparam int PP_W = 7;
  localparam int OFS_W = 16;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CPR_W-1:0] CPR_RESET = 20'd4096;
  localparam logic [PP_W-1:0] PP_RESET = 7'd1;
  localparam logic [OFS_W-1:0] OFS_RESET = 16'd0;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_CPR = 2'd0,
    REG_PP = 2'd1,
    REG_OFS = 2'd2,
    REG_UNUSED = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_UP = 2'd1,
    STEP_DOWN = 2'd2,
    STEP_BAD = 2'd3
  } step_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

  // x4 Gray decode of {previous BA, current BA}.
  function automatic step_t step_of(input logic [3:0] idx);
    step_t s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = STEP_UP;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_DOWN;
      default: s = STEP_HOLD;
    endcase
    return s;
  endfunction

endpackage

@@ src/qea_front.sv @@
// Front end: takes commands and pin samples, keeps the position count and index flag.
// Depends on qea_pkg; pushes each new count and flag into qea_queue.
module qea_front import qea_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  input  logic                  in_a,
  input  logic                  in_b,
  input  logic                  in_z,
  input  logic [LOAD_W-1:0]     in_load,
  input  logic                  q_full,
  output q_ctl_t                ctl,
  output logic                  in_ready,
  output logic [COUNT_BITS:0]   q_data
);

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [1:0]            last_r, last_nxt;
  logic                  zprev_r, zprev_nxt;
  logic                  flag_r, flag_nxt;
  logic                  take;
  logic [1:0]            cur;
  logic [63:0]           load_ext;
  step_t                 st;

  assign in_ready = !q_full;
  assign take = in_valid && !q_full;
  assign cur = {in_b, in_a};
  assign st = step_of({last_r, cur});
  assign load_ext = 64'(signed'(in_load));

  always_comb begin
    count_nxt = count_r;
    last_nxt = last_r;
    zprev_nxt = zprev_r;
    flag_nxt = flag_r;
    case (cmd_t'(in_cmd))
      CMD_SAMPLE: begin
        case (st)
          STEP_UP: count_nxt = count_r + COUNT_BITS'(1);
          STEP_DOWN: count_nxt = count_r - COUNT_BITS'(1);
          default: count_nxt = count_r;
        endcase
        last_nxt = cur;
        if (in_z && !zprev_r) begin
          flag_nxt = 1'b1;
        end
        zprev_nxt = in_z;
      end
      CMD_LOAD: count_nxt = load_ext[COUNT_BITS-1:0];
      CMD_CLEAR: flag_nxt = 1'b0;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      last_r <= '0;
      zprev_r <= 1'b0;
      flag_r <= 1'b0;
    end else if (take) begin
      count_r <= count_nxt;
      last_r <= last_nxt;
      zprev_r <= zprev_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign q_data = {flag_nxt, count_nxt};
  assign ctl.push = take;
  assign ctl.full = q_full;

endmodule

@@ src/qea_queue.sv @@
// Two-entry register queue between the front end and the angle unit.
// Depends on qea_pkg.
module qea_queue import qea_pkg::*; #(
  parameter int WIDTH = COUNT_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_ctl_t           ctl,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_pop;

  assign full = (cnt_r == CW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop = pop && not_empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (ctl.push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(ctl.push) - CW'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

@@ src/qea_back.sv @@
// Angle unit: multiply by pole pairs, floor-mod by counts per turn, scale to a turn
// fraction with a bit-serial divider, add the offset. Depends on qea_pkg.
module qea_back import qea_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [COUNT_BITS:0]   q_data,
  output logic                  q_pop,
  input  logic [CPR_W-1:0]      cpr,
  input  logic [PP_W-1:0]       pp,
  input  logic [OFS_W-1:0]      ofs,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] out_count,
  output logic [ANGLE_BITS-1:0] out_angle,
  output logic                  out_flag
);

  localparam int PW = COUNT_BITS + PP_W + 1;
  localparam int CW = $clog2(PW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_MOD  = 6'b000100,
    S_FIX  = 6'b001000,
    S_FRAC = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [COUNT_BITS-1:0]   cnt_val_r;
  logic                    flag_r;
  logic [PW-1:0]           mag_r;
  logic                    neg_r;
  logic [CPR_W-1:0]        rem_r;
  logic [ANGLE_BITS-1:0]   quo_r;
  logic [CW-1:0]           step_r;
  logic [CPR_W-1:0]        cpr_eff;
  logic signed [PW-1:0]    mul_a, mul_b, prod;
  logic [CPR_W:0]          mod_t, frac_t;
  logic                    mod_ge, frac_ge;
  logic [OFS_W+ANGLE_BITS-1:0] ofs_wide;
  logic [ANGLE_BITS-1:0]   ofs_ang;
  logic                    out_free;
  logic                    out_valid_r;
  logic [COUNT_BITS-1:0]   out_count_r;
  logic [ANGLE_BITS-1:0]   out_angle_r;
  logic                    out_flag_r;

  assign cpr_eff = (cpr == '0) ? CPR_W'(1) : cpr;
  assign mul_a = PW'(signed'(cnt_val_r));
  assign mul_b = signed'(PW'(pp));
  assign prod = mul_a * mul_b;
  assign mod_t = {rem_r, mag_r[PW-1]};
  assign mod_ge = (mod_t >= {1'b0, cpr_eff});
  assign frac_t = {rem_r, 1'b0};
  assign frac_ge = (frac_t >= {1'b0, cpr_eff});
  assign ofs_wide = {ofs, ANGLE_BITS'(0)};
  assign ofs_ang = ofs_wide[OFS_W+ANGLE_BITS-1:OFS_W];
  assign out_free = !out_valid_r || out_ready;
  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_MUL;
      S_MUL: state_nxt = S_MOD;
      S_MOD: if (step_r == '0) state_nxt = S_FIX;
      S_FIX: state_nxt = S_FRAC;
      S_FRAC: if (step_r == '0) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cnt_val_r <= q_data[COUNT_BITS-1:0];
        flag_r <= q_data[COUNT_BITS];
      end
      S_MUL: begin
        neg_r <= prod[PW-1];
        mag_r <= prod[PW-1] ? PW'(-prod) : PW'(prod);
        rem_r <= '0;
        step_r <= CW'(PW - 1);
      end
      S_MOD: begin
        rem_r <= mod_ge ? CPR_W'(mod_t - {1'b0, cpr_eff}) : mod_t[CPR_W-1:0];
        mag_r <= {mag_r[PW-2:0], 1'b0};
        step_r <= step_r - CW'(1);
      end
      S_FIX: begin
        if (neg_r && rem_r != '0) begin
          rem_r <= cpr_eff - rem_r;
        end
        step_r <= CW'(ANGLE_BITS - 1);
      end
      S_FRAC: begin
        rem_r <= frac_ge ? CPR_W'(frac_t - {1'b0, cpr_eff}) : frac_t[CPR_W-1:0];
        quo_r <= {quo_r[ANGLE_BITS-2:0], frac_ge};
        step_r <= step_r - CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_count_r <= cnt_val_r;
          out_angle_r <= quo_r + ofs_ang;
          out_flag_r <= flag_r;
        end
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_angle = out_angle_r;
  assign out_flag = out_flag_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_FRAC) |-> rem_r < cpr_eff)
    else $error("remainder not below counts per turn");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |=> rem_r < cpr_eff)
    else $error("floor-mod result out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_MUL)
    else $error("queue pop without start of angle work");

endmodule

@@ src/quadrature_encoder_angle_core.sv @@
// Top level of the quadrature encoder angle core: registers, front end, queue, angle unit.
// Depends on qea_pkg, qea_front, qea_queue and qea_back.
//
// Channel | Dir | Handshake            | Contents
// in      | in  | in_tvalid/in_tready  | tuser: cmd; tdata: a, b, z, load_value
// out     | out | out_tvalid/out_tready| tuser: index_seen; tdata: count, angle
// cfg     | in  | cfg_we               | cfg_addr selects the register, cfg_wdata value
//
// The front end takes one item per cycle while the two-entry queue has room.
// The angle unit works on one item at a time and pops a new item from the queue only
// when idle; its bit-serial divider produces one remainder bit per cycle. Reset is
// synchronous and clears all control state. A stalled output holds the result; the
// queue absorbs two items.
module quadrature_encoder_angle_core import qea_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // Fields from bit 0: phase_a, phase_b, index_level, load_value[31:0], zero fill.
  input  logic [39:0]       in_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // Fields from bit 0: position_count, electrical_angle, zero fill.
  output logic [((COUNT_BITS+ANGLE_BITS+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0: index_seen.
  output logic              out_tuser,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int OW = ((COUNT_BITS + ANGLE_BITS + 7) / 8) * 8;

  logic [CPR_W-1:0]      cpr_r;
  logic [PP_W-1:0]       pp_r;
  logic [OFS_W-1:0]      ofs_r;
  q_ctl_t                ctl;
  logic                  q_full, q_valid, q_pop;
  logic [COUNT_BITS:0]   q_wdata, q_rdata;
  logic [COUNT_BITS-1:0] res_count;
  logic [ANGLE_BITS-1:0] res_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= CPR_RESET;
      pp_r <= PP_RESET;
      ofs_r <= OFS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_CPR: cpr_r <= cfg_wdata[CPR_W-1:0];
        REG_PP: pp_r <= cfg_wdata[PP_W-1:0];
        REG_OFS: ofs_r <= cfg_wdata[OFS_W-1:0];
        default: cpr_r <= cpr_r;
      endcase
    end
  end

  qea_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_a     (in_tdata[0]),
    .in_b     (in_tdata[1]),
    .in_z     (in_tdata[2]),
    .in_load  (in_tdata[34:3]),
    .q_full   (q_full),
    .ctl      (ctl),
    .in_ready (in_tready),
    .q_data   (q_wdata)
  );

  qea_queue #(.WIDTH(COUNT_BITS + 1)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_data   (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_data   (q_rdata)
  );

  qea_back #(.COUNT_BITS(COUNT_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .cpr       (cpr_r),
    .pp        (pp_r),
    .ofs       (ofs_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_count (res_count),
    .out_angle (res_angle),
    .out_flag  (out_tuser)
  );

  assign out_tdata = OW'({res_angle, res_count});

endmodule

@@ verif/quadrature_encoder_angle_core_test.sv @@
// Self-checking testbench for quadrature_encoder_angle_core: a queue-fed driver, a monitor,
// a position and angle predictor, and configuration phases written while the core is idle.
// Depends on qea_pkg and the core RTL in src.
`timescale 1ns / 1ps

module quadrature_encoder_angle_core_test;
  import qea_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic        a;
    logic        b;
    logic        z;
    logic [31:0] load;
  } pin_item_t;

  typedef struct {
    logic [31:0] count;
    logic [15:0] angle;
    logic        flag;
  } angle_result_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 150;
  localparam int STEP_DELTA[16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  pin_item_t pending_items[$];
  angle_result_t expected_results[$];
  pin_item_t driven_item;
  int errors = 0;
  int hold_token = 0;
  int in_gap = 0;
  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;

  logic [19:0] cpr_q = CPR_RESET;
  logic [6:0] pp_q = PP_RESET;
  logic [15:0] ofs_q = OFS_RESET;
  logic [31:0] count_q = '0;
  logic [1:0] phase_q = '0;
  logic z_q = 1'b0;
  logic flag_q = 1'b0;

  logic [1:0] walk_pos = '0;

  always #6 clk = ~clk;

  quadrature_encoder_angle_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [15:0] angle_from_count(logic [31:0] count);
    longint cpr;
    longint prod;
    longint m;
    longint frac;
    cpr = (cpr_q == 0) ? 1 : longint'(cpr_q);
    prod = longint'($signed(count)) * longint'(pp_q);
    m = prod % cpr;
    if (m < 0) m += cpr;
    frac = (m <<< 16) / cpr;
    return 16'(frac + longint'(ofs_q));
  endfunction

  function automatic angle_result_t advance_position(pin_item_t it);
    angle_result_t r;
    logic [1:0] cur;
    int d;
    case (it.cmd)
      CMD_SAMPLE: begin
        cur = {it.b, it.a};
        d = STEP_DELTA[{phase_q, cur}];
        count_q = count_q + 32'(d);
        phase_q = cur;
        if (it.z && !z_q) flag_q = 1'b1;
        z_q = it.z;
      end
      CMD_LOAD: count_q = it.load;
      CMD_CLEAR: flag_q = 1'b0;
      default: ;
    endcase
    r.count = count_q;
    r.angle = angle_from_count(count_q);
    r.flag = flag_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(advance_position(driven_item));
        in_gap = in_gaps_on ? $urandom_range(0, 14) : 0;
      end
      if (in_tvalid && !in_tready) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        driven_item = pending_items.pop_front();
        in_tdata <= {5'b0, driven_item.load, driven_item.z, driven_item.b, driven_item.a};
        in_tuser <= driven_item.cmd;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  int out_stall = 0;
  int hold_left = 0;
  int hold_seen = 0;
  angle_result_t exp_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result count=%h angle=%h flag=%b", $time,
                   out_tdata[31:0], out_tdata[47:32], out_tuser);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata[31:0] !== exp_r.count) begin
            $display("%0t: count expected %h actual %h", $time, exp_r.count, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[47:32] !== exp_r.angle) begin
            $display("%0t: angle expected %h actual %h", $time, exp_r.angle, out_tdata[47:32]);
            errors++;
          end
          if (out_tuser !== exp_r.flag) begin
            $display("%0t: index flag expected %b actual %b", $time, exp_r.flag, out_tuser);
            errors++;
          end
        end
        out_stall = out_gaps_on ? $urandom_range(0, 14) : 0;
      end
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending_items.size() == 0 && expected_results.size() == 0 && !in_tvalid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("quadrature_encoder_angle_core_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [19:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_CPR: cpr_q = value;
      REG_PP: pp_q = value[6:0];
      REG_OFS: ofs_q = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [19:0] cpr, logic [19:0] pp, logic [19:0] ofs);
    write_reg(REG_CPR, cpr);
    write_reg(REG_PP, pp);
    write_reg(REG_OFS, ofs);
  endtask

  task automatic queue_item(cmd_t cmd, logic a, logic b, logic z, logic [31:0] load);
    pin_item_t it;
    it.cmd = cmd;
    it.a = a;
    it.b = b;
    it.z = z;
    it.load = load;
    pending_items.push_back(it);
  endtask

  function automatic logic [1:0] gray_of(logic [1:0] pos);
    return (pos == 2'd2) ? 2'b11 : (pos == 2'd3) ? 2'b10 : pos;
  endfunction

  task automatic queue_walk_step();
    int r;
    logic [1:0] ba;
    r = $urandom_range(0, 99);
    if (r < 42) walk_pos = walk_pos + 2'd1;
    else if (r < 82) walk_pos = walk_pos - 2'd1;
    else if (r < 86) walk_pos = walk_pos + 2'd2;
    ba = gray_of(walk_pos);
    if (r < 90) begin
      queue_item(CMD_SAMPLE, ba[0], ba[1], ($urandom_range(0, 9) == 0), $urandom());
    end else if (r < 94) begin
      queue_item(CMD_LOAD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)),
                 $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 200)) - 100));
    end else if (r < 97) begin
      queue_item(CMD_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), $urandom());
    end else if (r < 98) begin
      queue_item(CMD_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), $urandom());
    end else begin
      queue_item(CMD_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), $urandom());
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_config(20'd4096, 20'd1, 20'd0);

    queue_item(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'h0);
    queue_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b0, 32'h0);
    queue_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 32'h0);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'h0);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h0);
    queue_item(CMD_CLEAR, 1'b0, 1'b0, 1'b1, 32'h0);
    queue_item(CMD_NONE, 1'b1, 1'b0, 1'b1, 32'h1234_5678);
    queue_item(CMD_LOAD, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF);
    queue_item(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, 32'h0);
    queue_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h0);
    queue_item(CMD_LOAD, 1'b1, 1'b1, 1'b1, 32'h8000_0000);
    queue_item(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, 32'h0);
    queue_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'h0);
    queue_item(CMD_LOAD, 1'b0, 1'b0, 1'b0, 32'h0);
    queue_item(CMD_LOAD, 1'b0, 1'b0, 1'b0, 32'hFFFF_F000);
    queue_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b1, 32'h0);
    queue_item(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 32'h0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(20'd1, 20'd0, 20'd0);
        1: set_config(20'hFFFFF, 20'd64, 20'hFFFF);
        2: set_config(20'd1000, 20'd7, 20'd12345);
        3: set_config(20'd0, 20'd127, 20'd1);
        4: set_config(20'd3, 20'd1, 20'd32768);
        default: set_config(20'($urandom_range(1, 20'hFFFFF)), 20'($urandom_range(1, 64)),
                            20'($urandom_range(0, 16'hFFFF)));
      endcase
      in_gaps_on = (ph != 1);
      out_gaps_on = (ph != 4);
      if (ph == 2) hold_token++;
      repeat (55) queue_walk_step();
      drain();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("quadrature_encoder_angle_core_test OK");
    end else begin
      $display("quadrature_encoder_angle_core_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/qea_pkg.sv
src/qea_front.sv
src/qea_queue.sv
src/qea_back.sv
src/quadrature_encoder_angle_core.sv
verif/quadrature_encoder_angle_core_test.sv
